@@ rtl/modexp_pkg.sv @@
// Package for the modular exponentiation block.
// Holds the word widths, configuration register indexes, reset values and FSM state type.
// No dependencies.
package modexp_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int EXP_WIDTH = 32;
    localparam int BIT_IDX_WIDTH = $clog2(EXP_WIDTH);
    localparam int MUL_CNT_WIDTH = $clog2(WORD_WIDTH);
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 8'd1;

    localparam logic [WORD_WIDTH-1:0] MODULUS_RESET = 32'd12785039;
    localparam logic [WORD_WIDTH-1:0] EXPONENT_RESET = 32'd6553;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_STEP   = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

@@ rtl/modexp_mulmod.sv @@
// Shared modular multiplier: interleaved shift-and-add, one multiplier bit per cycle.
// Depends on modexp_pkg for the word width and counter width.
module modexp_mulmod #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [MOD_WIDTH-1:0]             op_a,
    input  logic [modexp_pkg::WORD_WIDTH-1:0] op_b,
    input  logic [MOD_WIDTH-1:0]             modulus,
    output logic                             done,
    output logic [MOD_WIDTH-1:0]             product
);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic [modexp_pkg::MUL_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [MOD_WIDTH-1:0]                 a_reg, a_next;
    logic [modexp_pkg::WORD_WIDTH-1:0]    b_reg, b_next;
    logic [MOD_WIDTH-1:0]                 r_reg, r_next;
    logic [MOD_WIDTH+1:0]                 sum;
    logic [MOD_WIDTH+1:0]                 n1;
    logic [MOD_WIDTH+1:0]                 n2;
    logic [MOD_WIDTH+1:0]                 reduced;

    // The remainder and op_a stay below the modulus, so the sum stays below three times it.
    always_comb
    begin
        n1 = {2'b00, modulus};
        n2 = {1'b0, modulus, 1'b0};
        sum = {1'b0, r_reg, 1'b0}
            + (b_reg[modexp_pkg::WORD_WIDTH-1] ? {2'b00, a_reg} : '0);
        if (sum >= n2)
        begin
            reduced = sum - n2;
        end
        else if (sum >= n1)
        begin
            reduced = sum - n1;
        end
        else
        begin
            reduced = sum;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = modexp_pkg::MUL_CNT_WIDTH'(modexp_pkg::WORD_WIDTH - 1);
            a_next = op_a;
            b_next = op_b;
            r_next = '0;
        end
        else if (busy_reg)
        begin
            r_next = reduced[MOD_WIDTH-1:0];
            b_next = {b_reg[modexp_pkg::WORD_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign product = r_reg;

endmodule

@@ rtl/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: configuration registers and sequencer.
// Depends on modexp_pkg and modexp_mulmod.
//
// Each base item is raised to the exponent register modulo the low MOD_WIDTH bits of the
// modulus register, scanning the exponent from its top bit. Leading zero exponent bits are
// skipped one by one in the step state. From the highest set bit down, every bit costs a
// modular square, and every set bit adds a modular multiply. The shared bit-serial
// multiplier handles one multiplier bit per cycle. A zero exponent or zero modulus goes
// straight from idle to the finish state. The block takes no new item while one is in
// progress, and it accepts the next item while a result waits. Configuration writes are
// always accepted and must be made only while the block is idle.
module modular_exponentiation #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]      base_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [modexp_pkg::WORD_WIDTH-1:0]      power_result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]      cfg_data
);

    modexp_pkg::state_t                   state_reg, state_next;
    logic [modexp_pkg::WORD_WIDTH-1:0]    modulus_reg, modulus_next;
    logic [modexp_pkg::WORD_WIDTH-1:0]    exponent_reg, exponent_next;
    logic [MOD_WIDTH-1:0]                 acc_reg, acc_next;
    logic [modexp_pkg::WORD_WIDTH-1:0]    base_reg, base_next;
    logic [modexp_pkg::BIT_IDX_WIDTH-1:0] bit_idx_reg, bit_idx_next;
    logic                                 started_reg, started_next;
    logic [modexp_pkg::WORD_WIDTH-1:0]    res_reg, res_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [modexp_pkg::WORD_WIDTH-1:0]    power_result_reg, power_result_next;

    logic                                 mm_start;
    logic [MOD_WIDTH-1:0]                 mm_a;
    logic [modexp_pkg::WORD_WIDTH-1:0]    mm_b;
    logic                                 mm_done;
    logic [MOD_WIDTH-1:0]                 mm_product;
    logic [MOD_WIDTH-1:0]                 n;
    logic                                 ebit;

    assign n = modulus_reg[MOD_WIDTH-1:0];
    assign ebit = exponent_reg[bit_idx_reg];

    modexp_mulmod #(
        .MOD_WIDTH(MOD_WIDTH)
    ) u_mulmod (
        .clk(clk),
        .rst_n(rst_n),
        .start(mm_start),
        .op_a(mm_a),
        .op_b(mm_b),
        .modulus(n),
        .done(mm_done),
        .product(mm_product)
    );

    always_comb
    begin
        state_next = state_reg;
        modulus_next = modulus_reg;
        exponent_next = exponent_reg;
        acc_next = acc_reg;
        base_next = base_reg;
        bit_idx_next = bit_idx_reg;
        started_next = started_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        power_result_next = power_result_reg;
        mm_start = 1'b0;
        mm_a = acc_reg;
        mm_b = modexp_pkg::WORD_WIDTH'(acc_reg);

        if (cfg_valid)
        begin
            if (cfg_index == modexp_pkg::CFG_MODULUS)
            begin
                modulus_next = cfg_data;
            end
            else if (cfg_index == modexp_pkg::CFG_EXPONENT)
            begin
                exponent_next = cfg_data;
            end
        end

        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    base_next = base_value;
                    if (exponent_reg == '0)
                    begin
                        res_next = modexp_pkg::WORD_WIDTH'(1);
                        state_next = modexp_pkg::ST_FINISH;
                    end
                    else if (n == '0)
                    begin
                        res_next = '0;
                        state_next = modexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        acc_next = (n == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                        bit_idx_next = modexp_pkg::BIT_IDX_WIDTH'(modexp_pkg::EXP_WIDTH - 1);
                        started_next = 1'b0;
                        state_next = modexp_pkg::ST_STEP;
                    end
                end
            end
            modexp_pkg::ST_STEP:
            begin
                if (!started_reg && !ebit)
                begin
                    if (bit_idx_reg == '0)
                    begin
                        res_next = modexp_pkg::WORD_WIDTH'(acc_reg);
                        state_next = modexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                    end
                end
                else
                begin
                    started_next = 1'b1;
                    mm_start = 1'b1;
                    state_next = modexp_pkg::ST_SQUARE;
                end
            end
            modexp_pkg::ST_SQUARE:
            begin
                if (mm_done)
                begin
                    acc_next = mm_product;
                    if (ebit)
                    begin
                        mm_start = 1'b1;
                        mm_a = mm_product;
                        mm_b = base_reg;
                        state_next = modexp_pkg::ST_MULT;
                    end
                    else if (bit_idx_reg == '0)
                    begin
                        res_next = modexp_pkg::WORD_WIDTH'(mm_product);
                        state_next = modexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                        state_next = modexp_pkg::ST_STEP;
                    end
                end
            end
            modexp_pkg::ST_MULT:
            begin
                if (mm_done)
                begin
                    acc_next = mm_product;
                    if (bit_idx_reg == '0)
                    begin
                        res_next = modexp_pkg::WORD_WIDTH'(mm_product);
                        state_next = modexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                        state_next = modexp_pkg::ST_STEP;
                    end
                end
            end
            modexp_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    power_result_next = res_reg;
                    state_next = modexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modexp_pkg::ST_IDLE;
            modulus_reg <= modexp_pkg::MODULUS_RESET;
            exponent_reg <= modexp_pkg::EXPONENT_RESET;
            bit_idx_reg <= '0;
            started_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            modulus_reg <= modulus_next;
            exponent_reg <= exponent_next;
            bit_idx_reg <= bit_idx_next;
            started_reg <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        base_reg <= base_next;
        res_reg <= res_next;
        power_result_reg <= power_result_next;
    end

    assign in_ready = (state_reg == modexp_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign power_result = power_result_reg;

endmodule
